// File: sv/jsde_pkg.sv
package jsde_pkg;

  localparam int SampleBitsDefault = 12;
  localparam int CenterW = 12;
  localparam int RepeatW = 8;
  localparam int MsW = 16;
  localparam int TickW = 8;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [CenterW-1:0] CenterLowReset = 12'd1700;
  localparam logic [CenterW-1:0] CenterHighReset = 12'd2400;
  localparam logic [RepeatW-1:0] RepeatPollsReset = 8'd7;
  localparam logic [MsW-1:0] PressMinReset = 16'd80;
  localparam logic [MsW-1:0] LongPressReset = 16'd800;
  localparam logic [TickW-1:0] TickMsReset = 8'd36;

  typedef enum logic [2:0] {
    REG_CENTER_LOW = 3'd0,
    REG_CENTER_HIGH = 3'd1,
    REG_REPEAT_POLLS = 3'd2,
    REG_PRESS_MIN = 3'd3,
    REG_LONG_PRESS = 3'd4,
    REG_TICK_MS = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_CENTER = 3'd0,
    DIR_LEFT = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP = 3'd3,
    DIR_DOWN = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    BTN_NONE = 2'd0,
    BTN_PRESS = 2'd1,
    BTN_LONG = 2'd2
  } btn_ev_t;

  typedef struct packed {
    logic [MsW-1:0] press_min_ms;
    logic [MsW-1:0] long_hold_ms;
    logic [TickW-1:0] tick_ms;
  } btn_cfg_t;

endpackage

// File: sv/joystick_direction_and_button_events.sv
// Joystick direction and button event decoder.
// Input stream: one transaction per poll tick, carrying both stick samples and
// three button samples. Output stream: exactly one transaction per input, with
// a direction event (valid flag and code) and a button event.
// The result is registered at the edge that accepts the input, in the result
// register or, while that holds a waiting result, in the skid register.
// Throughput is one tick per cycle while s_axis_tready is high; the decode
// and the repeat and press-timer updates are combinational, ahead of the registers.
// A two-entry output (result register plus skid register) lets the block take
// one more transaction while a result waits; once both hold data, s_axis_tready
// drops until the receiver takes one. No result is dropped or repeated.
// Reset (synchronous, rst high) clears both output entries, sets the last
// direction to center, clears the repeat counter and the button state, and
// loads the register defaults. Registers sit on an APB port at byte address
// 4*index; the user must write them only while the stream is idle, unenforced.
module joystick_direction_and_button_events
  import jsde_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [SB-1:0] x_sample, [2SB-1:SB] y_sample, [2SB] button_first,
  // [2SB+1] button_second, [2SB+2] button_third, rest zero
  input  logic [((2*SAMPLE_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] direction_valid, [3:1] direction, [5:4] button_event, [7:6] zero
  output logic [7:0]          m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int SB = SAMPLE_BITS;

  logic [CenterW-1:0] center_low;
  logic [CenterW-1:0] center_high;
  logic [RepeatW-1:0] repeat_polls;
  btn_cfg_t btn_cfg;
  reg_idx_t reg_sel;
  logic cfg_write;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ApbAddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_low <= CenterLowReset;
      center_high <= CenterHighReset;
      repeat_polls <= RepeatPollsReset;
      btn_cfg.press_min_ms <= PressMinReset;
      btn_cfg.long_hold_ms <= LongPressReset;
      btn_cfg.tick_ms <= TickMsReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_CENTER_LOW: center_low <= pwdata[CenterW-1:0];
        REG_CENTER_HIGH: center_high <= pwdata[CenterW-1:0];
        REG_REPEAT_POLLS: repeat_polls <= pwdata[RepeatW-1:0];
        REG_PRESS_MIN: btn_cfg.press_min_ms <= pwdata[MsW-1:0];
        REG_LONG_PRESS: btn_cfg.long_hold_ms <= pwdata[MsW-1:0];
        REG_TICK_MS: btn_cfg.tick_ms <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_LOW: prdata = ApbDataW'(center_low);
      REG_CENTER_HIGH: prdata = ApbDataW'(center_high);
      REG_REPEAT_POLLS: prdata = ApbDataW'(repeat_polls);
      REG_PRESS_MIN: prdata = ApbDataW'(btn_cfg.press_min_ms);
      REG_LONG_PRESS: prdata = ApbDataW'(btn_cfg.long_hold_ms);
      REG_TICK_MS: prdata = ApbDataW'(btn_cfg.tick_ms);
      default: prdata = '0;
    endcase
  end

  // Input transaction
  logic accept;
  logic [SB-1:0] x_sample;
  logic [SB-1:0] y_sample;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign x_sample = s_axis_tdata[SB-1:0];
  assign y_sample = s_axis_tdata[2*SB-1:SB];

  dir_t dir_now;
  btn_ev_t button_event;

  jsde_dir_decode #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dir_decode (
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .center_low (center_low),
    .center_high(center_high),
    .direction  (dir_now)
  );

  jsde_button u_button (
    .clk          (clk),
    .rst          (rst),
    .tick         (accept),
    .button_first (s_axis_tdata[2*SB]),
    .button_second(s_axis_tdata[2*SB+1]),
    .button_third (s_axis_tdata[2*SB+2]),
    .cfg          (btn_cfg),
    .button_event (button_event)
  );

  // Direction change and auto-repeat
  dir_t last_direction;
  dir_t last_direction_next;
  logic [RepeatW-1:0] repeat_counter;
  logic [RepeatW-1:0] repeat_counter_next;
  logic [RepeatW-1:0] repeat_inc;
  logic direction_valid;
  dir_t direction_out;

  always_comb begin
    repeat_inc = repeat_counter + RepeatW'(1);
    last_direction_next = last_direction;
    repeat_counter_next = repeat_counter;
    direction_valid = 1'b0;
    direction_out = DIR_CENTER;
    if (dir_now != last_direction) begin
      direction_valid = 1'b1;
      direction_out = dir_now;
      last_direction_next = dir_now;
      repeat_counter_next = '0;
    end else if (dir_now != DIR_CENTER) begin
      repeat_counter_next = repeat_inc;
      if (repeat_inc >= repeat_polls) begin
        direction_valid = 1'b1;
        direction_out = dir_now;
        repeat_counter_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction <= DIR_CENTER;
      repeat_counter <= '0;
    end else if (accept) begin
      last_direction <= last_direction_next;
      repeat_counter <= repeat_counter_next;
    end
  end

  // Result register with skid entry
  logic [7:0] result;
  logic out_valid;
  logic [7:0] out_data;
  logic skid_valid;
  logic [7:0] skid_data;

  assign result = {2'b00, button_event, direction_out, direction_valid};
  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      // drain the skid entry first to keep order
      out_valid <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

// File: sv/jsde_dir_decode.sv
module jsde_dir_decode
  import jsde_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDefault
) (
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic [CenterW-1:0]     center_low,
  input  logic [CenterW-1:0]     center_high,
  output dir_t                   direction
);

  localparam int CmpW = (SAMPLE_BITS > CenterW) ? SAMPLE_BITS : CenterW;

  logic [CmpW-1:0] xe;
  logic [CmpW-1:0] ye;
  logic [CmpW-1:0] lo;
  logic [CmpW-1:0] hi;
  logic [CmpW-1:0] mid;
  logic [CenterW:0] mid_sum;
  logic signed [CmpW:0] dx;
  logic signed [CmpW:0] dy;
  logic [CmpW:0] ax;
  logic [CmpW:0] ay;
  logic in_zone;

  always_comb begin
    xe = CmpW'(x_sample);
    ye = CmpW'(y_sample);
    lo = CmpW'(center_low);
    hi = CmpW'(center_high);
    mid_sum = {1'b0, center_low} + {1'b0, center_high};
    mid = CmpW'(mid_sum[CenterW:1]);
    in_zone = (xe >= lo) && (xe <= hi) && (ye >= lo) && (ye <= hi);
    dx = $signed({1'b0, xe}) - $signed({1'b0, mid});
    dy = $signed({1'b0, ye}) - $signed({1'b0, mid});
    ax = dx[CmpW] ? $unsigned(-dx) : $unsigned(dx);
    ay = dy[CmpW] ? $unsigned(-dy) : $unsigned(dy);
    // ties go to the vertical axis
    if (in_zone) begin
      direction = DIR_CENTER;
    end else if (ax > ay) begin
      direction = dx[CmpW] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      direction = dy[CmpW] ? DIR_UP : DIR_DOWN;
    end
  end

endmodule

// File: sv/jsde_button.sv
module jsde_button
  import jsde_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     tick,
  input  logic     button_first,
  input  logic     button_second,
  input  logic     button_third,
  input  btn_cfg_t cfg,
  output btn_ev_t  button_event
);

  logic button_held;
  logic button_held_next;
  logic [MsW-1:0] held_time_ms;
  logic [MsW-1:0] held_time_ms_next;
  logic long_reported;
  logic long_reported_next;
  logic released;
  logic [MsW:0] time_sum;
  logic [MsW-1:0] time_sat;

  always_comb begin
    // majority of three, active low
    released = (button_first & button_second) | (button_first & button_third) |
               (button_second & button_third);
    time_sum = {1'b0, held_time_ms} + (MsW + 1)'(cfg.tick_ms);
    time_sat = time_sum[MsW] ? {MsW{1'b1}} : time_sum[MsW-1:0];

    button_held_next = button_held;
    held_time_ms_next = held_time_ms;
    long_reported_next = long_reported;
    button_event = BTN_NONE;

    if (!released && !button_held) begin
      button_held_next = 1'b1;
      held_time_ms_next = '0;
      long_reported_next = 1'b0;
    end else if (released && button_held) begin
      button_held_next = 1'b0;
      held_time_ms_next = time_sat;
      long_reported_next = 1'b0;
      if (time_sat >= cfg.press_min_ms) begin
        button_event = BTN_PRESS;
      end
    end else if (!released && button_held) begin
      held_time_ms_next = time_sat;
      if (!long_reported && time_sat >= cfg.long_hold_ms) begin
        button_event = BTN_LONG;
        long_reported_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held <= 1'b0;
      held_time_ms <= '0;
      long_reported <= 1'b0;
    end else if (tick) begin
      button_held <= button_held_next;
      held_time_ms <= held_time_ms_next;
      long_reported <= long_reported_next;
    end
  end

endmodule
